FILE: rtl/text_console_writer_top_macros.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_CONSOLE_WRITER_TOP_MACROS_SVH

// same-cycle implication
`define TCW_ASSERT_NOW(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("tcw assertion failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("tcw assertion failed");

`endif

FILE: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants shared by the text console writer modules.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COL_W    = 7;
  localparam int ROW_W    = 5;
  localparam int CHAR_W   = 8;
  localparam int COLOR_W  = 4;
  localparam int CELL_W   = 16;
  localparam int CALC_W   = 16;
  localparam int OP_W     = 2;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_SETLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_RETURN   = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LINEFEED = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_LAST     = 8'h7F;

  localparam logic [1:0] REG_COLS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_BG   = 2'd2;
  localparam logic [1:0] REG_FG   = 2'd3;

  localparam logic [COL_W-1:0]   RESET_COLS = 7'd80;
  localparam logic [ROW_W-1:0]   RESET_ROWS = 5'd25;
  localparam logic [COLOR_W-1:0] RESET_BG   = 4'd0;
  localparam logic [COLOR_W-1:0] RESET_FG   = 4'd7;

  typedef enum logic [2:0] {
    CMD_PRINT,
    CMD_RETURN,
    CMD_LINEFEED,
    CMD_IGNORE,
    CMD_SETLOC,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] cell_val;
    logic              scrolled;
  } res_t;

  typedef struct packed {
    logic [COL_W-1:0]   cols;
    logic [ROW_W-1:0]   rows;
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
  } cfg_t;

endpackage

FILE: rtl/tcw_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_fifo
// Small synchronous queue used between front and back and on the results.
// ----------------------------------------------------------------------------
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = data_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

FILE: rtl/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Accepts input items and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
  input  logic              push_i,
  output logic              full_o,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [ROW_W-1:0]  target_row_i,
  input  logic [COL_W-1:0]  target_column_i,
  input  logic              init_busy_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output cmd_t              cmd_o
);

  assign full_o   = q_full_i || init_busy_i;
  assign q_push_o = push_i && !full_o;

  always_comb begin
    cmd_o.ch  = char_code_i;
    cmd_o.row = target_row_i;
    cmd_o.col = target_column_i;
    unique case (operation_i)
      OP_PUT: begin
        if (char_code_i == CHAR_RETURN) begin
          cmd_o.kind = CMD_RETURN;
        end else if (char_code_i == CHAR_LINEFEED) begin
          cmd_o.kind = CMD_LINEFEED;
        end else if (char_code_i >= CHAR_SPACE && char_code_i <= CHAR_LAST) begin
          cmd_o.kind = CMD_PRINT;
        end else begin
          cmd_o.kind = CMD_IGNORE;
        end
      end
      OP_SETLOC: cmd_o.kind = CMD_SETLOC;
      OP_CLEAR:  cmd_o.kind = CMD_CLEAR;
      OP_READ:   cmd_o.kind = CMD_READ;
      default:   cmd_o.kind = CMD_IGNORE;
    endcase
  end

endmodule

FILE: rtl/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Executes commands against the screen memory and cursor.
// ----------------------------------------------------------------------------
`include "text_console_writer_top_macros.svh"

module tcw_back import tcw_pkg::*; #(
  parameter int MAX_COLUMNS = 80,
  parameter int MAX_ROWS    = 25
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o,
  output logic init_busy_o
);

  localparam int Depth = MAX_COLUMNS * MAX_ROWS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [CALC_W-1:0] DepthC  = CALC_W'(Depth);
  localparam logic [CALC_W-1:0] LastIdx = CALC_W'(Depth - 1);
  localparam logic [7:0] MaxCol8 = 8'(MAX_COLUMNS);
  localparam logic [7:0] MaxRow8 = 8'(MAX_ROWS);

  localparam logic [3:0] S_INIT  = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_PUTW  = 4'd3;
  localparam logic [3:0] S_CHK   = 4'd4;
  localparam logic [3:0] S_SCRRD = 4'd5;
  localparam logic [3:0] S_SCRWR = 4'd6;
  localparam logic [3:0] S_CLR   = 4'd7;
  localparam logic [3:0] S_RDA   = 4'd8;
  localparam logic [3:0] S_RDD   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [CALC_W-1:0] j_q, j_d;
  logic              scrl_q, scrl_d;
  logic              hit_q, hit_d;
  cmd_t              cmd_q;
  logic [CALC_W-1:0] addr_q, addr_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic [CALC_W-1:0] area_q, moved_q;
  logic [CELL_W-1:0] rdata_q;
  logic [CELL_W-1:0] screen_mem_q [Depth];

  logic [COL_W-1:0]  w;
  logic [ROW_W-1:0]  h;
  logic [CHAR_W-1:0] attr;
  logic [CELL_W-1:0] blank;
  logic [COL_W-1:0]  col_inc;
  logic              tgt_hit;
  logic              mem_we, mem_re;
  logic [CALC_W-1:0] mem_waddr, mem_raddr;
  logic [CELL_W-1:0] mem_wdata;

  always_comb begin
    if (cfg_i.cols == '0) begin
      w = COL_W'(1);
    end else if ({1'b0, cfg_i.cols} > MaxCol8) begin
      w = MaxCol8[COL_W-1:0];
    end else begin
      w = cfg_i.cols;
    end
    if (cfg_i.rows == '0) begin
      h = ROW_W'(1);
    end else if ({3'b0, cfg_i.rows} > MaxRow8) begin
      h = MaxRow8[ROW_W-1:0];
    end else begin
      h = cfg_i.rows;
    end
  end

  assign attr    = {cfg_i.bg, cfg_i.fg};
  assign blank   = {attr, CHAR_SPACE};
  assign col_inc = col_q + 1'b1;
  assign tgt_hit = (cmd_q.row < h) && (cmd_q.col < w);

  assign init_busy_o = (state_q == S_INIT);
  assign res_o.row      = row_q;
  assign res_o.col      = col_q;
  assign res_o.cell_val = cell_q;
  assign res_o.scrolled = scrl_q;

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    j_d       = j_q;
    scrl_d    = scrl_q;
    hit_d     = hit_q;
    addr_d    = addr_q;
    cell_d    = cell_q;
    mem_we    = 1'b0;
    mem_waddr = j_q;
    mem_wdata = blank;
    mem_re    = 1'b0;
    mem_raddr = j_q + CALC_W'(w);
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    unique case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (j_q == LastIdx) begin
          j_d     = '0;
          state_d = S_IDLE;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        scrl_d = 1'b0;
        cell_d = '0;
        unique case (cmd_q.kind)
          CMD_PRINT: begin
            addr_d = CALC_W'(row_q) * CALC_W'(w) + CALC_W'(col_q);
            if (col_inc >= w) begin
              row_d = row_q + 1'b1;
              col_d = '0;
            end else begin
              col_d = col_inc;
            end
            state_d = S_PUTW;
          end
          CMD_RETURN: begin
            col_d   = '0;
            state_d = S_CHK;
          end
          CMD_LINEFEED: begin
            col_d   = '0;
            row_d   = row_q + 1'b1;
            state_d = S_CHK;
          end
          CMD_IGNORE: state_d = S_CHK;
          CMD_SETLOC: begin
            if (tgt_hit) begin
              row_d = cmd_q.row;
              col_d = cmd_q.col;
            end
            state_d = S_DONE;
          end
          CMD_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            j_d     = '0;
            state_d = S_CLR;
          end
          CMD_READ: begin
            addr_d  = CALC_W'(cmd_q.row) * CALC_W'(w) + CALC_W'(cmd_q.col);
            hit_d   = tgt_hit;
            state_d = S_RDA;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_PUTW: begin
        if (addr_q < DepthC) begin
          mem_we    = 1'b1;
          mem_waddr = addr_q;
          mem_wdata = {attr, cmd_q.ch};
        end
        state_d = S_CHK;
      end
      S_CHK: begin
        if (row_q >= h) begin
          row_d   = h - 1'b1;
          scrl_d  = 1'b1;
          j_d     = '0;
          state_d = S_SCRRD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCRRD: begin
        mem_re  = (j_q < moved_q);
        state_d = S_SCRWR;
      end
      S_SCRWR: begin
        mem_we    = 1'b1;
        mem_wdata = (j_q < moved_q) ? rdata_q : blank;
        if (j_q == area_q - 1'b1) begin
          state_d = S_DONE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_SCRRD;
        end
      end
      S_CLR: begin
        mem_we = 1'b1;
        if (j_q == area_q - 1'b1) begin
          state_d = S_DONE;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_RDA: begin
        mem_re    = hit_q;
        mem_raddr = addr_q;
        state_d   = S_RDD;
      end
      S_RDD: begin
        cell_d  = hit_q ? rdata_q : '0;
        state_d = S_DONE;
      end
      S_DONE: begin
        res_push_o = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      row_q   <= '0;
      col_q   <= '0;
      j_q     <= '0;
      scrl_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      j_q     <= j_d;
      scrl_q  <= scrl_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
    addr_q  <= addr_d;
    cell_q  <= cell_d;
    area_q  <= CALC_W'(h) * CALC_W'(w);
    moved_q <= area_q - CALC_W'(w);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      screen_mem_q[mem_waddr[AddrW-1:0]] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= screen_mem_q[mem_raddr[AddrW-1:0]];
    end
  end

  `TCW_ASSERT_NOW(a_res_space, clk_i, rst_ni, res_push_o, !res_full_i)
  `TCW_ASSERT_NOW(a_scroll_row, clk_i, rst_ni, res_push_o && res_o.scrolled, res_o.row == h - 1'b1)
  `TCW_ASSERT_NOW(a_wr_in_store, clk_i, rst_ni, mem_we, mem_waddr < DepthC)
  `TCW_ASSERT_NEXT(a_pop_exec, clk_i, rst_ni, cmd_pop_o, state_q == S_EXEC)

endmodule

FILE: rtl/text_console_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console: put, set location, clear and read cell.
// ----------------------------------------------------------------------------
// Each accepted item runs from EXEC to DONE before the next is popped; a clear
// writes every cell of the screen in turn, and a scrolling put copies each row
// up by one and blanks the last row, one cell at a time.
// One item is executed at a time; a two-entry queue on each side decouples.
// After reset all MAX_COLUMNS*MAX_ROWS cells (2000 by default) of the memory
// are zeroed with full held high; configuration writes are taken meanwhile.
module text_console_writer_top import tcw_pkg::*; #(
  parameter int MAX_COLUMNS = 80,
  parameter int MAX_ROWS    = 25,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [CHAR_W-1:0]  char_code_i,
  input  logic [ROW_W-1:0]   target_row_i,
  input  logic [COL_W-1:0]   target_column_i,
  output logic               empty,
  input  logic               pop,
  output logic [ROW_W-1:0]   cursor_row_out_o,
  output logic [COL_W-1:0]   cursor_column_out_o,
  output logic [CELL_W-1:0]  cell_value_o,
  output logic               did_scroll_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       cfg_wr;

  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_t cmd_in, cmd_out;
  logic res_push, res_full;
  res_t res_in, res_out;
  logic init_busy;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cols <= RESET_COLS;
      cfg_q.rows <= RESET_ROWS;
      cfg_q.bg   <= RESET_BG;
      cfg_q.fg   <= RESET_FG;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_COLS: cfg_q.cols <= pwdata[COL_W-1:0];
        REG_ROWS: cfg_q.rows <= pwdata[ROW_W-1:0];
        REG_BG:   cfg_q.bg   <= pwdata[COLOR_W-1:0];
        REG_FG:   cfg_q.fg   <= pwdata[COLOR_W-1:0];
        default:  cfg_q.fg   <= cfg_q.fg;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_COLS: prdata = PDATA_W'(cfg_q.cols);
      REG_ROWS: prdata = PDATA_W'(cfg_q.rows);
      REG_BG:   prdata = PDATA_W'(cfg_q.bg);
      REG_FG:   prdata = PDATA_W'(cfg_q.fg);
      default:  prdata = '0;
    endcase
  end

  tcw_front u_front (
    .push_i          (push),
    .full_o          (full),
    .operation_i     (operation_i),
    .char_code_i     (char_code_i),
    .target_row_i    (target_row_i),
    .target_column_i (target_column_i),
    .init_busy_i     (init_busy),
    .q_full_i        (cmd_full),
    .q_push_o        (cmd_push),
    .cmd_o           (cmd_in)
  );

  tcw_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  tcw_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .init_busy_o (init_busy)
  );

  tcw_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop),
    .rdata_o (res_out),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign cursor_row_out_o    = res_out.row;
  assign cursor_column_out_o = res_out.col;
  assign cell_value_o        = res_out.cell_val;
  assign did_scroll_o        = res_out.scrolled;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, set location, clear and read cell items into the console and
// checks every result against a cycle-free screen and cursor model kept here.
// Covers control and unprintable bytes, wrapping, scrolling, out-of-range
// targets, a cursor left outside a shrunken screen, and several register
// settings from the smallest screen to out-of-range register values. Both
// handshakes idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int SCREEN_MAX_COLS = 80;
  localparam int SCREEN_MAX_ROWS = 25;
  localparam int STORE_CELLS     = SCREEN_MAX_COLS * SCREEN_MAX_ROWS;
  // worst case is a full-size scroll on every item, plus stalls
  localparam int CYCLE_LIMIT     = 6000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [OP_W-1:0]    operation_i = OP_PUT;
  logic [CHAR_W-1:0]  char_code_i = '0;
  logic [ROW_W-1:0]   target_row_i = '0;
  logic [COL_W-1:0]   target_column_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [ROW_W-1:0]   cursor_row_out_o;
  logic [COL_W-1:0]   cursor_column_out_o;
  logic [CELL_W-1:0]  cell_value_o;
  logic               did_scroll_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  text_console_writer_top #(
    .MAX_COLUMNS(SCREEN_MAX_COLS),
    .MAX_ROWS   (SCREEN_MAX_ROWS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .operation_i        (operation_i),
    .char_code_i        (char_code_i),
    .target_row_i       (target_row_i),
    .target_column_i    (target_column_i),
    .empty              (empty),
    .pop                (pop),
    .cursor_row_out_o   (cursor_row_out_o),
    .cursor_column_out_o(cursor_column_out_o),
    .cell_value_o       (cell_value_o),
    .did_scroll_o       (did_scroll_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Console model state
  logic [CELL_W-1:0]  screen_copy [STORE_CELLS] = '{default: '0};
  int                 cursor_row_copy = 0;
  int                 cursor_col_copy = 0;
  logic [COL_W-1:0]   cfg_cols = RESET_COLS;
  logic [ROW_W-1:0]   cfg_rows = RESET_ROWS;
  logic [COLOR_W-1:0] cfg_bg = RESET_BG;
  logic [COLOR_W-1:0] cfg_fg = RESET_FG;

  res_t due_results[$];
  int   mismatch_count = 0;
  int   results_seen = 0;
  int   cycle_count = 0;
  bit   steady_flow = 1'b0;
  int   pop_hold = 0;

  function automatic int screen_width();
    if (cfg_cols == 0) return 1;
    if (cfg_cols > SCREEN_MAX_COLS) return SCREEN_MAX_COLS;
    return int'(cfg_cols);
  endfunction

  function automatic int screen_height();
    if (cfg_rows == 0) return 1;
    if (cfg_rows > SCREEN_MAX_ROWS) return SCREEN_MAX_ROWS;
    return int'(cfg_rows);
  endfunction

  function automatic res_t advance_console(input logic [OP_W-1:0] op,
                                           input logic [CHAR_W-1:0] ch,
                                           input logic [ROW_W-1:0] trow,
                                           input logic [COL_W-1:0] tcol);
    int w;
    int h;
    int addr;
    logic [CELL_W-1:0] blank;
    res_t r;
    w = screen_width();
    h = screen_height();
    blank = {cfg_bg, cfg_fg, CHAR_SPACE};
    r = '0;
    case (op)
      OP_PUT: begin
        if (ch == CHAR_RETURN) begin
          cursor_col_copy = 0;
        end else if (ch == CHAR_LINEFEED) begin
          cursor_col_copy = 0;
          cursor_row_copy++;
        end else if (ch >= CHAR_SPACE && ch <= CHAR_LAST) begin
          addr = cursor_row_copy * w + cursor_col_copy;
          if (addr < STORE_CELLS) screen_copy[addr] = {cfg_bg, cfg_fg, ch};
          cursor_col_copy++;
          if (cursor_col_copy >= w) begin
            cursor_row_copy++;
            cursor_col_copy = 0;
          end
        end
        if (cursor_row_copy >= h) begin
          for (int i = 0; i < (h - 1) * w; i++) screen_copy[i] = screen_copy[i + w];
          for (int i = 0; i < w; i++) screen_copy[(h - 1) * w + i] = blank;
          cursor_row_copy = h - 1;
          r.scrolled = 1'b1;
        end
      end
      OP_SETLOC: begin
        if (trow < h && tcol < w) begin
          cursor_row_copy = int'(trow);
          cursor_col_copy = int'(tcol);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < h * w; i++) screen_copy[i] = blank;
        cursor_row_copy = 0;
        cursor_col_copy = 0;
      end
      default: begin
        if (trow < h && tcol < w) r.cell_val = screen_copy[int'(trow) * w + int'(tcol)];
      end
    endcase
    r.row = cursor_row_copy[ROW_W-1:0];
    r.col = cursor_col_copy[COL_W-1:0];
    return r;
  endfunction

  function automatic int idle_span();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= 30)
      $display("mismatch on result %0d: %s got 0x%0h want 0x%0h",
               results_seen, what, got, want);
  endtask

  always @(posedge clk_i) begin : check_result
    res_t want;
    if (rst_ni && pop && !empty) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with none outstanding", cursor_row_out_o, 0);
      end else begin
        want = due_results.pop_front();
        if (cursor_row_out_o !== want.row)
          report_mismatch("cursor_row_out", cursor_row_out_o, want.row);
        if (cursor_column_out_o !== want.col)
          report_mismatch("cursor_column_out", cursor_column_out_o, want.col);
        if (cell_value_o !== want.cell_val)
          report_mismatch("cell_value", cell_value_o, want.cell_val);
        if (did_scroll_o !== want.scrolled)
          report_mismatch("did_scroll", did_scroll_o, want.scrolled);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if (!steady_flow) pop_hold = idle_span();
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, due_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // push is left high after acceptance so back-to-back items need no gap
  task automatic send_op(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                         input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    int gap;
    gap = steady_flow ? 0 : idle_span();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push            <= 1'b1;
    operation_i     <= op;
    char_code_i     <= ch;
    target_row_i    <= row;
    target_column_i <= col;
    do @(posedge clk_i); while (full);
    due_results.push_back(advance_console(op, ch, row, col));
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_COLS: cfg_cols = value[COL_W-1:0];
      REG_ROWS: cfg_rows = value[ROW_W-1:0];
      REG_BG:   cfg_bg = value[COLOR_W-1:0];
      default:  cfg_fg = value[COLOR_W-1:0];
    endcase
  endtask

  task automatic apply_config(input int cols, input int rows, input int bg, input int fg);
    drain_results();
    write_reg(REG_COLS, PDATA_W'(cols));
    write_reg(REG_ROWS, PDATA_W'(rows));
    write_reg(REG_BG, PDATA_W'(bg));
    write_reg(REG_FG, PDATA_W'(fg));
  endtask

  task automatic random_item();
    int pick;
    int w;
    int h;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  tr;
    logic [COL_W-1:0]  tc;
    w    = screen_width();
    h    = screen_height();
    op   = OP_PUT;
    ch   = CHAR_W'($urandom_range(0, 255));
    tr   = ROW_W'($urandom_range(0, 31));
    tc   = COL_W'($urandom_range(0, 127));
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      ch = CHAR_W'($urandom_range(CHAR_SPACE, CHAR_LAST));
    end else if (pick < 63) begin
      ch = $urandom_range(0, 1) ? CHAR_RETURN : CHAR_LINEFEED;
    end else if (pick < 70) begin
      ch = $urandom_range(0, 1) ? CHAR_W'($urandom_range(0, 8'h1F))
                                : CHAR_W'($urandom_range(8'h80, 8'hFF));
    end else if (pick < 80) begin
      op = OP_SETLOC;
      tr = ROW_W'($urandom_range(0, h - 1));
      tc = COL_W'($urandom_range(0, w - 1));
    end else if (pick < 84) begin
      op = OP_SETLOC;
    end else if (pick < 94) begin
      op = OP_READ;
      tr = ROW_W'($urandom_range(0, h - 1));
      tc = COL_W'($urandom_range(0, w - 1));
    end else if (pick < 97) begin
      op = OP_READ;
    end else begin
      op = OP_CLEAR;
    end
    send_op(op, ch, tr, tc);
  endtask

  task automatic test_directed_basics();
    send_op(OP_READ, 8'h00, 5'd0, 7'd0);
    send_op(OP_PUT, CHAR_SPACE, 5'd0, 7'd0);
    send_op(OP_PUT, CHAR_LAST, 5'd31, 7'd127);
    send_op(OP_PUT, 8'h00, 5'd0, 7'd0);
    send_op(OP_PUT, 8'h1F, 5'd0, 7'd0);
    send_op(OP_PUT, 8'h80, 5'd0, 7'd0);
    send_op(OP_PUT, 8'hFF, 5'd0, 7'd0);
    send_op(OP_READ, 8'hFF, 5'd0, 7'd1);
    send_op(OP_PUT, CHAR_RETURN, 5'd0, 7'd0);
    send_op(OP_PUT, CHAR_LINEFEED, 5'd0, 7'd0);
    send_op(OP_SETLOC, 8'h00, 5'd24, 7'd79);
    send_op(OP_PUT, 8'h41, 5'd0, 7'd0);
    send_op(OP_SETLOC, 8'h00, 5'd25, 7'd0);
    send_op(OP_SETLOC, 8'h00, 5'd0, 7'd80);
    send_op(OP_SETLOC, 8'h00, 5'd31, 7'd127);
    send_op(OP_READ, 8'h00, 5'd23, 7'd79);
    send_op(OP_READ, 8'h00, 5'd24, 7'd0);
    send_op(OP_READ, 8'h00, 5'd0, 7'd80);
    send_op(OP_PUT, CHAR_LINEFEED, 5'd0, 7'd0);
    send_op(OP_CLEAR, 8'h00, 5'd0, 7'd0);
    send_op(OP_READ, 8'h00, 5'd24, 7'd79);
  endtask

  // cursor left beyond a screen that a register write then shrinks
  task automatic test_cursor_beyond_screen();
    send_op(OP_SETLOC, 8'h00, 5'd22, 7'd75);
    apply_config(10, 6, 15, 0);
    send_op(OP_PUT, 8'h5A, 5'd0, 7'd0);
    send_op(OP_READ, 8'h00, 5'd5, 7'd0);
    apply_config(80, 25, 15, 0);
    send_op(OP_SETLOC, 8'h00, 5'd20, 7'd3);
    apply_config(40, 4, 2, 11);
    send_op(OP_PUT, 8'h01, 5'd0, 7'd0);
    send_op(OP_READ, 8'h00, 5'd3, 7'd39);
  endtask

  task automatic test_random_traffic();
    int cols_list [8] = '{8, 1, 0, 127, 20, 80, 13, 80};
    int rows_list [8] = '{4, 1, 0, 31, 2, 3, 25, 25};
    int bg_list   [8] = '{1, 15, 0, 3, 10, 6, 12, 0};
    int fg_list   [8] = '{14, 15, 0, 9, 5, 12, 3, 7};
    int count_list[8] = '{60, 30, 25, 40, 70, 60, 60, 40};
    for (int p = 0; p < 8; p++) begin
      apply_config(cols_list[p], rows_list[p], bg_list[p], fg_list[p]);
      steady_flow = (p == 2 || p == 5);
      for (int n = 0; n < count_list[p]; n++) begin
        if ((p == 1 && n == count_list[p] / 2) || $urandom_range(0, 49) == 0)
          drain_results();
        random_item();
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_basics();
    drain_results();
    test_cursor_beyond_screen();
    test_random_traffic();
    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_fifo.sv
rtl/tcw_front.sv
rtl/tcw_back.sv
rtl/text_console_writer_top.sv
test/testbench.sv
